/* rtl/lockchk_pkg.sv */
// Shared types, field widths and controller opcodes for the lock order inversion checker.
`default_nettype none

package lockchk_pkg;

    // Default sizes handed to the top-level parameters.
    localparam int NUM_CLASSES_DEF = 64;
    localparam int STACK_DEPTH_DEF = 16;
    localparam int NUM_CPUS_DEF    = 4;

    // Fixed widths of the beat fields.
    localparam int CMD_W   = 1;
    localparam int CPU_W   = 2;
    localparam int CLASS_W = 6;
    localparam int MASK_W  = 16;
    localparam int DEPTH_W = 5;

    // Command field codes.
    localparam logic [CMD_W-1:0] CMD_ACQUIRE = 1'b0;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 1'b1;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [CPU_W-1:0]   cpu;
        logic [CLASS_W-1:0] class_in;
    } item_t;

    typedef struct packed {
        logic [CLASS_W-1:0] class_out;
        logic [MASK_W-1:0]  conflict_mask;
        logic [DEPTH_W-1:0] depth_after;
        logic               pushed;
        logic               removed;
    } result_t;

    // Datapath operations issued by the controller, one per cycle.
    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_NONE      = 4'd0;
    localparam logic [OP_W-1:0] OP_ACCEPT    = 4'd1;
    localparam logic [OP_W-1:0] OP_SETUP     = 4'd2;
    localparam logic [OP_W-1:0] OP_SKIP      = 4'd3;
    localparam logic [OP_W-1:0] OP_WALK      = 4'd4;
    localparam logic [OP_W-1:0] OP_PUSH      = 4'd5;
    localparam logic [OP_W-1:0] OP_SCAN      = 4'd6;
    localparam logic [OP_W-1:0] OP_MISS      = 4'd7;
    localparam logic [OP_W-1:0] OP_HIT       = 4'd8;
    localparam logic [OP_W-1:0] OP_REMOVE    = 4'd9;
    localparam logic [OP_W-1:0] OP_SHIFT     = 4'd10;
    localparam logic [OP_W-1:0] OP_SHIFT_END = 4'd11;

    typedef struct packed {
        logic [OP_W-1:0] op;
    } ctrl_t;

    typedef struct packed {
        logic release_cmd;
        logic cpu_ok;
        logic walk_done;
        logic scan_empty;
        logic scan_hit;
        logic hit_more;
        logic shift_more;
    } status_t;

endpackage

`default_nettype wire

/* rtl/lockchk_ctrl.sv */
// Sequencing state machine for the lock order inversion checker.
`default_nettype none

module lockchk_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire lockchk_pkg::status_t status,
    output logic                    busy,
    output lockchk_pkg::ctrl_t      ctrl
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SETUP  = 3'd1;
    localparam logic [2:0] ST_WALK   = 3'd2;
    localparam logic [2:0] ST_RSCAN  = 3'd3;
    localparam logic [2:0] ST_RSHIFT = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctrl.op    = lockchk_pkg::OP_NONE;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ctrl.op    = lockchk_pkg::OP_ACCEPT;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                if (!status.cpu_ok)
                begin
                    ctrl.op    = lockchk_pkg::OP_SKIP;
                    state_next = ST_IDLE;
                end
                else
                begin
                    ctrl.op    = lockchk_pkg::OP_SETUP;
                    state_next = status.release_cmd ? ST_RSCAN : ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (status.walk_done)
                begin
                    ctrl.op    = lockchk_pkg::OP_PUSH;
                    state_next = ST_IDLE;
                end
                else
                begin
                    ctrl.op = lockchk_pkg::OP_WALK;
                end
            end
            ST_RSCAN:
            begin
                if (status.scan_empty)
                begin
                    ctrl.op    = lockchk_pkg::OP_MISS;
                    state_next = ST_IDLE;
                end
                else if (status.scan_hit)
                begin
                    if (status.hit_more)
                    begin
                        ctrl.op    = lockchk_pkg::OP_HIT;
                        state_next = ST_RSHIFT;
                    end
                    else
                    begin
                        ctrl.op    = lockchk_pkg::OP_REMOVE;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    ctrl.op = lockchk_pkg::OP_SCAN;
                end
            end
            ST_RSHIFT:
            begin
                if (status.shift_more)
                begin
                    ctrl.op = lockchk_pkg::OP_SHIFT;
                end
                else
                begin
                    ctrl.op    = lockchk_pkg::OP_SHIFT_END;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

`default_nettype wire

/* rtl/lockchk_dp.sv */
// Datapath: class counter, held stacks, order matrix and result register.
`default_nettype none

module lockchk_dp #(
    parameter int NUM_CLASSES = lockchk_pkg::NUM_CLASSES_DEF,
    parameter int STACK_DEPTH = lockchk_pkg::STACK_DEPTH_DEF,
    parameter int NUM_CPUS    = lockchk_pkg::NUM_CPUS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire lockchk_pkg::item_t   item,
    input  wire lockchk_pkg::ctrl_t   ctrl,
    output lockchk_pkg::status_t      status,
    output logic                      done,
    output lockchk_pkg::result_t      result
);

    localparam int CW          = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int SEL_W       = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int DEP_W       = $clog2(STACK_DEPTH + 1);
    localparam int SA_W        = SEL_W + IDX_W;
    localparam int STK_ENTRIES = NUM_CPUS << IDX_W;
    localparam logic [CW-1:0]    CLS_MAX = CW'(NUM_CLASSES - 1);
    localparam logic [DEP_W-1:0] DEP_MAX = DEP_W'(STACK_DEPTH);

    logic [lockchk_pkg::CMD_W-1:0] cmd_reg;
    logic [lockchk_pkg::CPU_W-1:0] cpu_reg;
    logic [CW-1:0]                 cls_reg;
    logic [CW-1:0]                 last_reg;
    logic [DEP_W-1:0]              depth_reg;
    logic [DEP_W-1:0]              ptr_reg;
    logic [lockchk_pkg::MASK_W-1:0] mask_reg;
    logic [NUM_CLASSES-1:0]        rowc_reg;
    logic [NUM_CLASSES-1:0]        row_vld_reg;
    logic [DEP_W-1:0]              held_cnt_reg [NUM_CPUS];
    logic [CW-1:0]                 stk_q_reg;
    logic                          done_reg;
    lockchk_pkg::result_t          result_reg;
    lockchk_pkg::result_t          result_next;

    logic [NUM_CLASSES-1:0] order_mem [NUM_CLASSES];
    logic [CW-1:0]          stk_mem   [STK_ENTRIES];

    logic [CW-1:0]    cls_sat;
    logic [CW-1:0]    last_inc;
    logic [CW-1:0]    cls_new;
    logic             cpu_ok;
    logic [SEL_W-1:0] cpu_idx;
    logic [DEP_W-1:0] cur_cnt;
    logic [DEP_W-1:0] rd_idx;
    logic [SA_W-1:0]  stk_raddr;
    logic [SA_W-1:0]  stk_waddr;
    logic [CW-1:0]    stk_wdata;
    logic             stk_we;
    logic             push_ok;
    logic             mat_we;
    logic             test_hit;
    logic [DEP_W:0]   ptr_ext;
    logic [DEP_W:0]   depth_ext;
    logic             finish;

    // Class resolution: zero draws the next number from a saturating counter.
    assign cls_sat  = (32'(item.class_in) >= NUM_CLASSES) ? CLS_MAX : CW'(item.class_in);
    assign last_inc = (last_reg == CLS_MAX) ? last_reg : last_reg + 1'b1;
    assign cls_new  = (item.class_in == '0) ? last_inc : cls_sat;

    assign cpu_ok  = (32'(cpu_reg) < NUM_CPUS);
    assign cpu_idx = SEL_W'(cpu_reg);
    assign cur_cnt = held_cnt_reg[cpu_idx];

    assign ptr_ext   = {1'b0, ptr_reg};
    assign depth_ext = {1'b0, depth_reg};

    assign status.release_cmd = (cmd_reg == lockchk_pkg::CMD_RELEASE);
    assign status.cpu_ok      = cpu_ok;
    assign status.walk_done   = (ptr_reg == depth_reg);
    assign status.scan_empty  = (ptr_reg == '0);
    assign status.scan_hit    = (stk_q_reg == cls_reg);
    assign status.hit_more    = (ptr_reg < depth_reg);
    assign status.shift_more  = ((ptr_ext + (DEP_W + 1)'(2)) < depth_ext);

    // Stack read address for the entry that the next cycle inspects.
    always_comb
    begin
        unique case (ctrl.op)
            lockchk_pkg::OP_SETUP:
            begin
                rd_idx = status.release_cmd ? cur_cnt - 1'b1 : '0;
            end
            lockchk_pkg::OP_WALK:  rd_idx = ptr_reg + 1'b1;
            lockchk_pkg::OP_SCAN:  rd_idx = ptr_reg - DEP_W'(2);
            lockchk_pkg::OP_HIT:   rd_idx = ptr_reg;
            lockchk_pkg::OP_SHIFT: rd_idx = ptr_reg + DEP_W'(2);
            default:               rd_idx = '0;
        endcase
    end

    assign stk_raddr = {cpu_idx, rd_idx[IDX_W-1:0]};

    assign push_ok = (ctrl.op == lockchk_pkg::OP_PUSH) && (depth_reg < DEP_MAX);
    assign stk_we  = push_ok || (ctrl.op == lockchk_pkg::OP_SHIFT)
                             || (ctrl.op == lockchk_pkg::OP_SHIFT_END);
    assign stk_waddr = push_ok ? {cpu_idx, depth_reg[IDX_W-1:0]}
                               : {cpu_idx, ptr_reg[IDX_W-1:0]};
    assign stk_wdata = push_ok ? cls_reg : stk_q_reg;

    assign mat_we   = (ctrl.op == lockchk_pkg::OP_WALK);
    assign test_hit = rowc_reg[stk_q_reg];

    assign finish = (ctrl.op == lockchk_pkg::OP_PUSH)
                 || (ctrl.op == lockchk_pkg::OP_MISS)
                 || (ctrl.op == lockchk_pkg::OP_REMOVE)
                 || (ctrl.op == lockchk_pkg::OP_SHIFT_END)
                 || (ctrl.op == lockchk_pkg::OP_SKIP);

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_mem[stk_waddr] <= stk_wdata;
        end
        stk_q_reg <= stk_mem[stk_raddr];
    end

    // A row that was never written since reset holds stale bits, so its
    // first write stores the whole row.
    always_ff @(posedge clk)
    begin
        if (mat_we)
        begin
            if (row_vld_reg[stk_q_reg])
            begin
                order_mem[stk_q_reg][cls_reg] <= 1'b1;
            end
            else
            begin
                order_mem[stk_q_reg] <= NUM_CLASSES'(1) << cls_reg;
            end
        end
    end

    // Working copy of the new class's row; it follows self-dependency marks
    // made during the walk.
    always_ff @(posedge clk)
    begin
        if (ctrl.op == lockchk_pkg::OP_SETUP)
        begin
            rowc_reg <= row_vld_reg[cls_reg] ? order_mem[cls_reg] : '0;
        end
        else if (mat_we && (stk_q_reg == cls_reg))
        begin
            rowc_reg[cls_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg    <= '0;
            row_vld_reg <= '0;
            done_reg    <= 1'b0;
            for (int i = 0; i < NUM_CPUS; i++)
            begin
                held_cnt_reg[i] <= '0;
            end
        end
        else
        begin
            done_reg <= finish;
            if ((ctrl.op == lockchk_pkg::OP_ACCEPT) && (item.class_in == '0))
            begin
                last_reg <= last_inc;
            end
            if (mat_we)
            begin
                row_vld_reg[stk_q_reg] <= 1'b1;
            end
            if (push_ok)
            begin
                held_cnt_reg[cpu_idx] <= depth_reg + 1'b1;
            end
            else if ((ctrl.op == lockchk_pkg::OP_REMOVE)
                  || (ctrl.op == lockchk_pkg::OP_SHIFT_END))
            begin
                held_cnt_reg[cpu_idx] <= depth_reg - 1'b1;
            end
        end
    end

    always_comb
    begin
        result_next             = '0;
        result_next.class_out   = lockchk_pkg::CLASS_W'(cls_reg);
        result_next.depth_after = lockchk_pkg::DEPTH_W'(depth_reg);
        case (ctrl.op) inside
            lockchk_pkg::OP_PUSH:
            begin
                result_next.conflict_mask = mask_reg;
                if (push_ok)
                begin
                    result_next.depth_after = lockchk_pkg::DEPTH_W'(depth_reg + 1'b1);
                    result_next.pushed      = 1'b1;
                end
            end
            lockchk_pkg::OP_REMOVE, lockchk_pkg::OP_SHIFT_END:
            begin
                result_next.depth_after = lockchk_pkg::DEPTH_W'(depth_reg - 1'b1);
                result_next.removed     = 1'b1;
            end
            lockchk_pkg::OP_SKIP:
            begin
                result_next.depth_after = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        case (ctrl.op)
            lockchk_pkg::OP_ACCEPT:
            begin
                cmd_reg <= item.command;
                cpu_reg <= item.cpu;
                cls_reg <= cls_new;
            end
            lockchk_pkg::OP_SETUP:
            begin
                depth_reg <= cur_cnt;
                ptr_reg   <= status.release_cmd ? cur_cnt : '0;
                mask_reg  <= '0;
            end
            lockchk_pkg::OP_WALK:
            begin
                if (test_hit && (32'(ptr_reg) < lockchk_pkg::MASK_W))
                begin
                    mask_reg[4'(ptr_reg)] <= 1'b1;
                end
                ptr_reg <= ptr_reg + 1'b1;
            end
            lockchk_pkg::OP_SCAN:  ptr_reg <= ptr_reg - 1'b1;
            lockchk_pkg::OP_HIT:   ptr_reg <= ptr_reg - 1'b1;
            lockchk_pkg::OP_SHIFT: ptr_reg <= ptr_reg + 1'b1;
            default:
            begin
            end
        endcase

        if (finish)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

/* rtl/lock_order_inversion_checker.sv */
// Top level of the lock order inversion checker: controller plus datapath.
//
//   Channel | Handshake            | Payload
//   --------+----------------------+-------------------------------
//   input   | start, busy          | item   (command, cpu, class_in)
//   result  | done (one-cycle)     | result (class_out, conflict_mask,
//           |                      |         depth_after, pushed, removed)
//
// A beat is taken on a rising edge with start high and busy low.
// An acquire walks the held entries of its processor's stack; the walk reads one
// held entry per cycle from the stack memory and writes one order matrix row per
// cycle. A release scans top-down one entry per cycle and then shifts the entries
// above the match down one per cycle; a miss ends when the scan reaches the bottom.
// A beat for a processor beyond NUM_CPUS is dropped after setup, with depth_after
// reported as zero. Busy stays high until the item finishes.
// Reset clears the counters and the row valid bits at once; no clearing pass.
// The result beat stands for one cycle and the next input beat may be taken in it.
`default_nettype none

module lock_order_inversion_checker #(
    parameter int NUM_CLASSES = lockchk_pkg::NUM_CLASSES_DEF,
    parameter int STACK_DEPTH = lockchk_pkg::STACK_DEPTH_DEF,
    parameter int NUM_CPUS    = lockchk_pkg::NUM_CPUS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire lockchk_pkg::item_t item,
    output logic                    busy,
    output logic                    done,
    output lockchk_pkg::result_t    result
);

    lockchk_pkg::ctrl_t   ctrl;
    lockchk_pkg::status_t status;

    lockchk_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .busy   (busy),
        .ctrl   (ctrl)
    );

    lockchk_dp #(
        .NUM_CLASSES (NUM_CLASSES),
        .STACK_DEPTH (STACK_DEPTH),
        .NUM_CPUS    (NUM_CPUS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .ctrl   (ctrl),
        .status (status),
        .done   (done),
        .result (result)
    );

    a_done_follows_work: assert property (
        @(posedge clk) disable iff (!rst_n) done |-> $past(busy)
    ) else $error("result beat without an item in progress");

    a_accept_goes_busy: assert property (
        @(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy
    ) else $error("accepted beat did not start work");

    a_push_depth: assert property (
        @(posedge clk) disable iff (!rst_n)
        (done && result.pushed) |-> (result.depth_after != '0 && !result.removed)
    ) else $error("push reported with empty stack or removal");

    a_release_no_mask: assert property (
        @(posedge clk) disable iff (!rst_n)
        (done && result.removed) |-> (result.conflict_mask == '0)
    ) else $error("release reported a conflict mask");

endmodule

`default_nettype wire
